>>> design/sector_chain_walker_macros.svh
// Assertion macros for the sector chain walker.
`ifndef SECTOR_CHAIN_WALKER_MACROS_SVH
`define SECTOR_CHAIN_WALKER_MACROS_SVH
`ifndef SYNTH
`define SCW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scw assertion failed");
`define SCW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scw assertion failed");
`else
`define SCW_ASSERT(label, clk, rst, prop)
`define SCW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> design/scw_pkg.sv
// Types, constants and helper functions of the sector chain walker.
package scw_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SHIFT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ARENA_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_ENTRIES = 2'd2;

  localparam logic [4:0]  SHIFT_MAX   = 5'd20;
  localparam logic [4:0]  SHIFT_RESET = 5'd9;

  localparam logic [31:0] LINK_FREE = 32'hFFFF_FFFF;
  localparam logic [31:0] LINK_END  = 32'hFFFF_FFFE;
  localparam logic [31:0] LINK_FAT  = 32'hFFFF_FFFD;
  localparam logic [31:0] LINK_DIF  = 32'hFFFF_FFFC;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  function automatic logic [51:0] sector_offset(input logic [31:0] sector,
                                                input logic [4:0] shift);
    sector_offset = {20'd0, sector} << shift;
  endfunction

  function automatic logic walk_over(input logic [31:0] sector,
                                     input logic [31:0] written,
                                     input logic [31:0] target,
                                     input logic [12:0] links,
                                     input logic [4:0]  shift,
                                     input logic [31:0] arena,
                                     input logic [31:0] entries);
    logic sentinel;
    logic [51:0] off;
    sentinel = (sector == LINK_FREE) || (sector == LINK_END) ||
               (sector == LINK_FAT) || (sector == LINK_DIF);
    off = sector_offset(sector, shift);
    walk_over = sentinel || (written >= target) ||
                ({19'd0, links} >= entries + 32'd1) ||
                (off >= {20'd0, arena});
  endfunction

endpackage

>>> design/scw_if.sv
// Request and result channel interfaces of the sector chain walker.
interface scw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] entry_index;
  logic [31:0] entry_value;
  logic [31:0] first_sector;
  logic [63:0] declared_size;

  modport source(output valid, command, entry_index, entry_value, first_sector,
                 declared_size, input ready);
  modport sink(input valid, command, entry_index, entry_value, first_sector,
               declared_size, output ready);
endinterface

interface scw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_offset;
  logic [20:0] copy_length;
  logic [31:0] dest_offset;
  logic [31:0] zero_fill_length;
  logic [31:0] stream_size;
  logic        done_res;

  modport source(output valid, source_offset, copy_length, dest_offset,
                 zero_fill_length, stream_size, done_res, input ready);
  modport sink(input valid, source_offset, copy_length, dest_offset,
               zero_fill_length, stream_size, done_res, output ready);
endinterface

>>> design/sector_chain_walker.sv
// Sector chain walker: link table, walk state and copy descriptor generation.
//
// An item is registered when taken and executed in the EXEC state after it; no
// new item is taken before the last is through. The link table memory's
// registered read at the current sector must settle before a step can follow
// the link. A result that waits on the result channel holds execution, and the
// input stays closed until that result leaves the result register. Load items
// and items that produce no result leave nothing on the result channel.
`include "sector_chain_walker_macros.svh"

module sector_chain_walker (
  input  logic                               clk,
  input  logic                               rst,
  scw_in_if.sink                             req,
  scw_out_if.source                          rsp,
  input  logic                               cfg_we,
  input  logic [scw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scw_pkg::*;

  state_t state, state_next;

  logic [4:0]  chunk_shift;
  logic [31:0] arena_bytes;
  logic [12:0] table_entries;

  logic [1:0]  cmd_q;
  logic [11:0] index_q;
  logic [31:0] value_q;
  logic [31:0] start_q;
  logic [63:0] size_q;

  logic [31:0] link_mem [TABLE_DEPTH];
  logic [31:0] rd_link;

  logic [31:0] current_sector;
  logic [31:0] bytes_written;
  logic [31:0] target_size;
  logic [12:0] link_count;
  logic        walk_active;

  logic        out_valid;
  logic [31:0] out_source;
  logic [20:0] out_length;
  logic [31:0] out_dest;
  logic [31:0] out_zero;
  logic [31:0] out_total;
  logic        out_done;

  logic        out_free, has_result, fire, emit;
  logic [4:0]  eff_shift;
  logic [31:0] eff_entries;
  logic [51:0] off;
  logic [20:0] chunk;
  logic [31:0] avail, want, copy32, bw_new;
  logic [20:0] copy;
  logic        over0, done1, over1, step_done;
  logic [31:0] clamped;

  logic [31:0] res_source, res_dest, res_zero, res_size;
  logic [20:0] res_length;
  logic        res_done;

  always_comb begin
    eff_shift   = (chunk_shift > SHIFT_MAX) ? SHIFT_MAX : chunk_shift;
    eff_entries = ({19'd0, table_entries} > 32'(TABLE_DEPTH)) ?
                  32'(TABLE_DEPTH) : {19'd0, table_entries};
    off    = sector_offset(current_sector, eff_shift);
    chunk  = 21'd1 << eff_shift;
    over0  = walk_over(current_sector, bytes_written, target_size, link_count,
                       eff_shift, arena_bytes, eff_entries);
    avail  = arena_bytes - off[31:0];
    want   = target_size - bytes_written;
    copy32 = ({11'd0, chunk} < avail) ? {11'd0, chunk} : avail;
    if (copy32 > want) begin
      copy32 = want;
    end
    copy   = copy32[20:0];
    bw_new = bytes_written + copy32;
    done1  = (copy < chunk) || (current_sector >= eff_entries);
    over1  = walk_over(rd_link, bw_new, target_size, link_count + 13'd1,
                       eff_shift, arena_bytes, eff_entries);
    step_done = over0 || done1 || over1;
    clamped = (size_q > {32'd0, arena_bytes}) ? arena_bytes : size_q[31:0];
  end

  always_comb begin
    has_result = 1'b0;
    res_source = '0;
    res_length = '0;
    res_dest   = '0;
    res_zero   = '0;
    res_size   = target_size;
    res_done   = 1'b0;
    case (cmd_t'(cmd_q))
      CMD_START: begin
        has_result = 1'b1;
        res_size   = clamped;
        res_done   = (clamped == 32'd0);
      end
      CMD_STEP: begin
        has_result = walk_active;
        res_done   = 1'b1;
        res_dest   = bytes_written;
        if (over0) begin
          res_zero = target_size - bytes_written;
        end else begin
          res_source = off[31:0];
          res_length = copy;
          res_done   = step_done;
          res_zero   = step_done ? (target_size - bw_new) : 32'd0;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid || rsp.ready;
  assign fire     = (state == S_EXEC) && (!has_result || out_free);
  assign emit     = fire && has_result;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  req.ready = !rst;
      S_EXEC:  req.ready = 1'b0;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_shift   <= SHIFT_RESET;
      arena_bytes   <= '0;
      table_entries <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHUNK_SHIFT:   chunk_shift   <= cfg_data[4:0];
        REG_ARENA_BYTES:   arena_bytes   <= cfg_data[31:0];
        REG_TABLE_ENTRIES: table_entries <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q   <= req.command;
      index_q <= req.entry_index;
      value_q <= req.entry_value;
      start_q <= req.first_sector;
      size_q  <= req.declared_size;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (cmd_t'(cmd_q) == CMD_LOAD) && (32'(index_q) < 32'(TABLE_DEPTH))) begin
      link_mem[ADDR_W'(index_q)] <= value_q;
    end
    rd_link <= link_mem[current_sector[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_sector <= '0;
      bytes_written  <= '0;
      target_size    <= '0;
      link_count     <= '0;
      walk_active    <= 1'b0;
    end else if (emit) begin
      if (cmd_t'(cmd_q) == CMD_START) begin
        target_size    <= clamped;
        current_sector <= start_q;
        bytes_written  <= '0;
        link_count     <= '0;
        walk_active    <= (clamped != 32'd0);
      end else if (over0) begin
        walk_active <= 1'b0;
      end else begin
        bytes_written <= bw_new;
        walk_active   <= !step_done;
        if (!done1) begin
          current_sector <= rd_link;
          link_count     <= link_count + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_source <= res_source;
      out_length <= res_length;
      out_dest   <= res_dest;
      out_zero   <= res_zero;
      out_total  <= res_size;
      out_done   <= res_done;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.source_offset    = out_source;
  assign rsp.copy_length      = out_length;
  assign rsp.dest_offset      = out_dest;
  assign rsp.zero_fill_length = out_zero;
  assign rsp.stream_size      = out_total;
  assign rsp.done_res         = out_done;

  `SCW_ASSERT(a_accept_to_exec, clk, rst, (req.valid && req.ready) |=> (state == S_EXEC))
  `SCW_ASSERT(a_result_from_exec, clk, rst, $rose(out_valid) |-> $past(state == S_EXEC))
  `SCW_ASSERT(a_done_ends_walk, clk, rst, (emit && res_done) |=> !walk_active)
  `SCW_ASSERT(a_written_bound, clk, rst, bytes_written <= target_size)
  `SCW_ASSERT(a_no_emit_idle, clk, rst, (state == S_IDLE) |-> !emit)

endmodule
